[design/x86sid_pkg.sv]
// x86sid_pkg: types, opcode constants and byte helpers for the x86-64 subset decoder
// no dependencies; used by the predecode stage, the top level and the checker

package x86sid_pkg;

  // prefix and opcode bytes
  localparam logic [7:0] REX_MASK = 8'hF0;
  localparam logic [7:0] REX_TAG  = 8'h40;

  localparam logic [7:0] OPC_NOP      = 8'h90;
  localparam logic [7:0] OPC_RET      = 8'hC3;
  localparam logic [7:0] OPC_INT3     = 8'hCC;
  localparam logic [7:0] OPC_PUSH_RBP = 8'h55;
  localparam logic [7:0] OPC_POP_RBP  = 8'h5D;
  localparam logic [7:0] OPC_JE       = 8'h74;
  localparam logic [7:0] OPC_JNE      = 8'h75;
  localparam logic [7:0] OPC_JBE      = 8'h76;
  localparam logic [7:0] OPC_JA       = 8'h77;
  localparam logic [7:0] OPC_JMP8     = 8'hEB;
  localparam logic [7:0] OPC_JMP32    = 8'hE9;
  localparam logic [7:0] OPC_CALL     = 8'hE8;

  localparam logic [7:0] OPC_MOV_RM8     = 8'h88;
  localparam logic [7:0] OPC_MOV_RM      = 8'h89;
  localparam logic [7:0] OPC_MOV_REG     = 8'h8B;
  localparam logic [7:0] OPC_MOV_IMM     = 8'hC7;
  localparam logic [7:0] OPC_ADD_RM8     = 8'h00;
  localparam logic [7:0] OPC_ADD_RM      = 8'h01;
  localparam logic [7:0] OPC_ADD_REG8    = 8'h02;
  localparam logic [7:0] OPC_ADD_REG     = 8'h03;
  localparam logic [7:0] OPC_ADD_AL_IMM  = 8'h04;
  localparam logic [7:0] OPC_ADD_RAX_IMM = 8'h05;
  localparam logic [7:0] OPC_LEA         = 8'h8D;
  localparam logic [7:0] OPC_TEST        = 8'h85;
  localparam logic [7:0] OPC_GRP80       = 8'h80;
  localparam logic [7:0] OPC_GRP81       = 8'h81;
  localparam logic [7:0] OPC_GRP83       = 8'h83;

  // modrm / sib codes
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_RIP     = 3'd5;
  localparam logic [2:0] BASE_NONE  = 3'd5;
  localparam logic [2:0] INDEX_NONE = 3'd4;

  // fixed byte positions
  localparam logic [3:0] POS_OPC_END  = 4'd2;
  localparam logic [3:0] POS_MODRM_END = 4'd3;
  localparam logic [3:0] POS_SIB_END  = 4'd4;
  localparam logic [3:0] POS_REL      = 4'd1;
  localparam logic [3:0] LEN_ONE      = 4'd1;
  localparam logic [3:0] LEN_REL8     = 4'd2;
  localparam logic [3:0] LEN_REL32    = 4'd5;

  typedef enum logic [4:0] {
    OP_NOP      = 5'd0,
    OP_RET      = 5'd1,
    OP_INT3     = 5'd2,
    OP_PUSH_RBP = 5'd3,
    OP_POP_RBP  = 5'd4,
    OP_JE       = 5'd5,
    OP_JNE      = 5'd6,
    OP_JBE      = 5'd7,
    OP_JA       = 5'd8,
    OP_JMP      = 5'd9,
    OP_CALL     = 5'd10,
    OP_MOV      = 5'd11,
    OP_ADD      = 5'd12,
    OP_LEA      = 5'd13,
    OP_TEST     = 5'd14,
    OP_GRP80    = 5'd15,
    OP_GRP81    = 5'd16,
    OP_GRP83    = 5'd17,
    OP_UNKNOWN  = 5'd18
  } op_class_e;

  typedef enum logic [2:0] {
    FORM_NONE    = 3'd0,
    FORM_REG_REG = 3'd1,
    FORM_REG_MEM = 3'd2,
    FORM_MEM_REG = 3'd3,
    FORM_REG_IMM = 3'd4,
    FORM_MEM_IMM = 3'd5,
    FORM_BRANCH  = 3'd6
  } form_e;

  typedef enum logic [2:0] {
    AM_BASE       = 3'd0,
    AM_BASE_DISP  = 3'd1,
    AM_BASE_INDEX = 3'd2,
    AM_INDEX_DISP = 3'd3,
    AM_ABS        = 3'd4,
    AM_RIP        = 3'd5
  } amode_e;

  typedef enum logic [1:0] {
    ORD_RM_REG  = 2'd0,
    ORD_REG_RM  = 2'd1,
    ORD_RM_IMM  = 2'd2,
    ORD_ACC_IMM = 2'd3
  } ord_e;

  typedef enum logic [1:0] {
    SZ_NONE  = 2'd0,
    SZ_BYTE  = 2'd1,
    SZ_DWORD = 2'd2
  } size_e;

  typedef struct packed {
    logic      found;
    op_class_e cls;
    ord_e      ord;
    size_e     isz;
  } rex_op_t;

  typedef struct packed {
    logic [63:0] window_low;
    logic [63:0] window_high;
    logic [63:0] instr_address;
  } in_t;

  typedef struct packed {
    op_class_e          op_class;
    form_e              operand_form;
    logic [3:0]         reg_operand;
    logic [3:0]         base_or_rm_reg;
    amode_e             address_mode;
    logic [3:0]         index_reg;
    logic [1:0]         scale_log2;
    logic signed [31:0] displacement;
    logic signed [31:0] immediate;
    logic [3:0]         length;
    logic [63:0]        branch_target;
  } out_t;

  // predecoded shape of one instruction, handed from the first to the second stage
  typedef struct packed {
    logic [127:0]       window;
    logic [63:0]        instr_address;
    op_class_e          cls;
    form_e              form;
    logic [3:0]         regop;
    logic [3:0]         base;
    amode_e             amode;
    logic [3:0]         idx;
    logic [1:0]         scale;
    logic [3:0]         dpos;
    size_e              dsz;
    logic [3:0]         ipos;
    size_e              isz;
    logic [3:0]         len;
    logic               branch;
    logic signed [32:0] offs;
  } predec_t;

  function automatic rex_op_t rex_lookup(input logic [7:0] opc);
    rex_op_t r;
    r = '{found: 1'b1, cls: OP_UNKNOWN, ord: ORD_RM_REG, isz: SZ_NONE};
    unique case (opc)
      OPC_MOV_RM8:     r.cls = OP_MOV;
      OPC_MOV_RM:      r.cls = OP_MOV;
      OPC_MOV_REG:     begin r.cls = OP_MOV; r.ord = ORD_REG_RM; end
      OPC_MOV_IMM:     begin r.cls = OP_MOV; r.ord = ORD_RM_IMM; r.isz = SZ_DWORD; end
      OPC_ADD_RM8:     r.cls = OP_ADD;
      OPC_ADD_RM:      r.cls = OP_ADD;
      OPC_ADD_REG8:    begin r.cls = OP_ADD; r.ord = ORD_REG_RM; end
      OPC_ADD_REG:     begin r.cls = OP_ADD; r.ord = ORD_REG_RM; end
      OPC_ADD_AL_IMM:  begin r.cls = OP_ADD; r.ord = ORD_ACC_IMM; r.isz = SZ_BYTE; end
      OPC_ADD_RAX_IMM: begin r.cls = OP_ADD; r.ord = ORD_ACC_IMM; r.isz = SZ_DWORD; end
      OPC_LEA:         begin r.cls = OP_LEA; r.ord = ORD_REG_RM; end
      OPC_TEST:        r.cls = OP_TEST;
      OPC_GRP80:       begin r.cls = OP_GRP80; r.ord = ORD_RM_IMM; r.isz = SZ_BYTE; end
      OPC_GRP81:       begin r.cls = OP_GRP81; r.ord = ORD_RM_IMM; r.isz = SZ_DWORD; end
      OPC_GRP83:       begin r.cls = OP_GRP83; r.ord = ORD_RM_IMM; r.isz = SZ_BYTE; end
      default:         r.found = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] size_bytes(input size_e s);
    logic [3:0] n;
    unique case (s)
      SZ_NONE:  n = 4'd0;
      SZ_BYTE:  n = 4'd1;
      SZ_DWORD: n = 4'd4;
      default:  n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [7:0] get_byte(input logic [127:0] w, input logic [3:0] p);
    return w[{p, 3'b000} +: 8];
  endfunction

  // little-endian dword, positions wrap inside the window
  function automatic logic [31:0] rd32(input logic [127:0] w, input logic [3:0] p);
    return {get_byte(w, p + 4'd3), get_byte(w, p + 4'd2),
            get_byte(w, p + 4'd1), get_byte(w, p)};
  endfunction

endpackage

[design/x86sid_predecode.sv]
// x86sid_predecode: first decode stage, finds prefix, opcode, modrm/sib shape,
// field positions, length and the branch offset; uses x86sid_pkg

module x86sid_predecode (
  input  x86sid_pkg::in_t     beat_i,
  output x86sid_pkg::predec_t pd_o
);

  logic [127:0]        win;
  logic [7:0]          byte0;
  logic [7:0]          byte1;
  logic [7:0]          modrm;
  logic [7:0]          sib;
  logic                is_rex;
  logic                rr;
  logic                rx;
  logic                rb;
  logic [1:0]          md;
  logic [2:0]          reg_f;
  logic [2:0]          rm;
  logic [1:0]          ss;
  logic [2:0]          ix;
  logic [2:0]          bs;
  logic                has_idx;
  logic                no_base;
  logic                rel32;
  logic [31:0]         rel;
  x86sid_pkg::rex_op_t op;

  assign win     = {beat_i.window_high, beat_i.window_low};
  assign byte0   = win[7:0];
  assign byte1   = win[15:8];
  assign modrm   = win[23:16];
  assign sib     = win[31:24];
  assign is_rex  = (byte0 & x86sid_pkg::REX_MASK) == x86sid_pkg::REX_TAG;
  assign rr      = byte0[2];
  assign rx      = byte0[1];
  assign rb      = byte0[0];
  assign md      = modrm[7:6];
  assign reg_f   = modrm[5:3];
  assign rm      = modrm[2:0];
  assign ss      = sib[7:6];
  assign ix      = sib[5:3];
  assign bs      = sib[2:0];
  assign has_idx = !(ix == x86sid_pkg::INDEX_NONE && !rx);
  assign no_base = (md == x86sid_pkg::MOD_NODISP) && (bs == x86sid_pkg::BASE_NONE);
  assign op      = x86sid_pkg::rex_lookup(byte1);

  always_comb begin
    pd_o               = '0;
    pd_o.window        = win;
    pd_o.instr_address = beat_i.instr_address;
    pd_o.cls           = x86sid_pkg::OP_UNKNOWN;
    pd_o.form          = x86sid_pkg::FORM_NONE;
    pd_o.amode         = x86sid_pkg::AM_BASE;
    pd_o.dpos          = x86sid_pkg::POS_MODRM_END;
    pd_o.dsz           = x86sid_pkg::SZ_NONE;
    pd_o.ipos          = x86sid_pkg::POS_OPC_END;
    pd_o.isz           = x86sid_pkg::SZ_NONE;
    pd_o.len           = x86sid_pkg::LEN_ONE;
    pd_o.branch        = 1'b0;
    rel32              = 1'b0;
    rel                = '0;

    if (is_rex) begin
      pd_o.len = x86sid_pkg::POS_OPC_END;
      if (op.found) begin
        pd_o.cls = op.cls;
        if (op.ord == x86sid_pkg::ORD_ACC_IMM) begin
          // accumulator form: no modrm, imm right after the opcode
          pd_o.form = x86sid_pkg::FORM_REG_IMM;
          pd_o.isz  = op.isz;
        end else begin
          pd_o.regop = {rr, reg_f};
          if (md == x86sid_pkg::MOD_REG) begin
            pd_o.base = {rb, rm};
            pd_o.form = (op.ord == x86sid_pkg::ORD_RM_IMM) ? x86sid_pkg::FORM_REG_IMM
                                                           : x86sid_pkg::FORM_REG_REG;
          end else begin
            unique case (op.ord)
              x86sid_pkg::ORD_RM_REG: pd_o.form = x86sid_pkg::FORM_MEM_REG;
              x86sid_pkg::ORD_REG_RM: pd_o.form = x86sid_pkg::FORM_REG_MEM;
              default:                pd_o.form = x86sid_pkg::FORM_MEM_IMM;
            endcase
            if (rm == x86sid_pkg::RM_SIB) begin
              pd_o.dpos = x86sid_pkg::POS_SIB_END;
              if (has_idx) begin
                pd_o.idx   = {rx, ix};
                pd_o.scale = ss;
              end
              if (!no_base) begin
                pd_o.base = {rb, bs};
              end
              if (no_base) begin
                pd_o.amode = has_idx ? x86sid_pkg::AM_INDEX_DISP : x86sid_pkg::AM_ABS;
              end else if (has_idx) begin
                pd_o.amode = x86sid_pkg::AM_BASE_INDEX;
              end else begin
                pd_o.amode = (md == x86sid_pkg::MOD_NODISP) ? x86sid_pkg::AM_BASE
                                                            : x86sid_pkg::AM_BASE_DISP;
              end
              if (no_base || md == x86sid_pkg::MOD_DISP32) begin
                pd_o.dsz = x86sid_pkg::SZ_DWORD;
              end else if (md == x86sid_pkg::MOD_DISP8) begin
                pd_o.dsz = x86sid_pkg::SZ_BYTE;
              end
            end else if (md == x86sid_pkg::MOD_NODISP && rm == x86sid_pkg::RM_RIP) begin
              pd_o.amode = x86sid_pkg::AM_RIP;
              pd_o.dsz   = x86sid_pkg::SZ_DWORD;
            end else begin
              pd_o.base = {rb, rm};
              unique case (md)
                x86sid_pkg::MOD_NODISP: pd_o.amode = x86sid_pkg::AM_BASE;
                x86sid_pkg::MOD_DISP8: begin
                  pd_o.amode = x86sid_pkg::AM_BASE_DISP;
                  pd_o.dsz   = x86sid_pkg::SZ_BYTE;
                end
                default: begin
                  pd_o.amode = x86sid_pkg::AM_BASE_DISP;
                  pd_o.dsz   = x86sid_pkg::SZ_DWORD;
                end
              endcase
            end
          end
          if (op.ord == x86sid_pkg::ORD_RM_IMM) begin
            pd_o.isz = op.isz;
          end
          pd_o.ipos = pd_o.dpos + x86sid_pkg::size_bytes(pd_o.dsz);
        end
        pd_o.len = pd_o.ipos + x86sid_pkg::size_bytes(pd_o.isz);
      end
    end else begin
      unique case (byte0)
        x86sid_pkg::OPC_NOP:      pd_o.cls = x86sid_pkg::OP_NOP;
        x86sid_pkg::OPC_RET:      pd_o.cls = x86sid_pkg::OP_RET;
        x86sid_pkg::OPC_INT3:     pd_o.cls = x86sid_pkg::OP_INT3;
        x86sid_pkg::OPC_PUSH_RBP: pd_o.cls = x86sid_pkg::OP_PUSH_RBP;
        x86sid_pkg::OPC_POP_RBP:  pd_o.cls = x86sid_pkg::OP_POP_RBP;
        x86sid_pkg::OPC_JE:       begin pd_o.cls = x86sid_pkg::OP_JE;  pd_o.branch = 1'b1; end
        x86sid_pkg::OPC_JNE:      begin pd_o.cls = x86sid_pkg::OP_JNE; pd_o.branch = 1'b1; end
        x86sid_pkg::OPC_JBE:      begin pd_o.cls = x86sid_pkg::OP_JBE; pd_o.branch = 1'b1; end
        x86sid_pkg::OPC_JA:       begin pd_o.cls = x86sid_pkg::OP_JA;  pd_o.branch = 1'b1; end
        x86sid_pkg::OPC_JMP8:     begin pd_o.cls = x86sid_pkg::OP_JMP; pd_o.branch = 1'b1; end
        x86sid_pkg::OPC_JMP32: begin
          pd_o.cls    = x86sid_pkg::OP_JMP;
          pd_o.branch = 1'b1;
          rel32       = 1'b1;
        end
        x86sid_pkg::OPC_CALL: begin
          pd_o.cls    = x86sid_pkg::OP_CALL;
          pd_o.branch = 1'b1;
          rel32       = 1'b1;
        end
        default:                  pd_o.cls = x86sid_pkg::OP_UNKNOWN;
      endcase
      if (pd_o.branch) begin
        pd_o.form = x86sid_pkg::FORM_BRANCH;
        pd_o.len  = rel32 ? x86sid_pkg::LEN_REL32 : x86sid_pkg::LEN_REL8;
        rel       = rel32 ? x86sid_pkg::rd32(win, x86sid_pkg::POS_REL) : x86sid_pkg::sx8(byte1);
        // offset past the end of the instruction, 33 bits so it cannot overflow
        pd_o.offs = {rel[31], rel} + {29'd0, pd_o.len};
      end
    end
  end

endmodule

[design/x86_64_subset_instruction_decoder_top.sv]
// throughput: one instruction window per cycle, sustained while the output is not stalled
// three register stages: input capture, predecode, field extraction with target add
// a stall on the output holds each full stage that has only full stages after it; the others keep moving and filling
// reset (rst_ni low, asynchronous) empties all stages; payload registers are not reset
//
// x86_64_subset_instruction_decoder_top: pipelined decoder for a small x86-64 subset
// uses x86sid_pkg and x86sid_predecode

module x86_64_subset_instruction_decoder_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  x86sid_pkg::in_t   in_beat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output x86sid_pkg::out_t  out_beat_o
);

  // stage valids
  logic                v1_q, v2_q, v3_q;
  // per-stage load enables: a stage takes new data when empty or when it drains
  logic                rdy1, rdy2, rdy3;

  // stage payloads
  x86sid_pkg::in_t     in1_q;
  x86sid_pkg::predec_t pd_d;
  x86sid_pkg::predec_t pd2_q;
  x86sid_pkg::out_t    out_d;
  x86sid_pkg::out_t    out3_q;

  logic [31:0]         disp_val;
  logic [31:0]         imm_val;
  logic [63:0]         target;

  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // stall toward the sender only when the input stage is full and cannot move
  assign in_stall_o  = !rdy1;
  assign out_valid_o = v3_q;
  assign out_beat_o  = out3_q;

  // ---------------------------------------------------------------- stage 1 -> 2
  // prefix / opcode lookup, modrm and sib shape, byte positions, length,
  // and the branch offset relative to the instruction end
  x86sid_predecode u_predecode (
    .beat_i (in1_q),
    .pd_o   (pd_d)
  );

  // ---------------------------------------------------------------- stage 2 -> 3
  // pull displacement and immediate from the positions the predecode stage found
  always_comb begin
    unique case (pd2_q.dsz)
      x86sid_pkg::SZ_BYTE:  disp_val = x86sid_pkg::sx8(x86sid_pkg::get_byte(pd2_q.window,
                                                                            pd2_q.dpos));
      x86sid_pkg::SZ_DWORD: disp_val = x86sid_pkg::rd32(pd2_q.window, pd2_q.dpos);
      default:              disp_val = '0;
    endcase
  end

  always_comb begin
    unique case (pd2_q.isz)
      x86sid_pkg::SZ_BYTE:  imm_val = x86sid_pkg::sx8(x86sid_pkg::get_byte(pd2_q.window,
                                                                           pd2_q.ipos));
      x86sid_pkg::SZ_DWORD: imm_val = x86sid_pkg::rd32(pd2_q.window, pd2_q.ipos);
      default:              imm_val = '0;
    endcase
  end

  // branch target: address plus the sign-extended offset, wraps at 64 bits
  assign target = pd2_q.branch
                ? pd2_q.instr_address + {{31{pd2_q.offs[32]}}, pd2_q.offs}
                : '0;

  always_comb begin
    out_d.op_class       = pd2_q.cls;
    out_d.operand_form   = pd2_q.form;
    out_d.reg_operand    = pd2_q.regop;
    out_d.base_or_rm_reg = pd2_q.base;
    out_d.address_mode   = pd2_q.amode;
    out_d.index_reg      = pd2_q.idx;
    out_d.scale_log2     = pd2_q.scale;
    out_d.displacement   = signed'(disp_val);
    out_d.immediate      = signed'(imm_val);
    out_d.length         = pd2_q.len;
    out_d.branch_target  = target;
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      in1_q <= in_beat_i;
    end
    if (rdy2 && v1_q) begin
      pd2_q <= pd_d;
    end
    if (rdy3 && v2_q) begin
      out3_q <= out_d;
    end
  end

endmodule

[design/x86sid_checker.sv]
// x86sid_checker: port-level checks for the decoder top level, attached by bind
// uses x86sid_pkg; binds to x86_64_subset_instruction_decoder_top

module x86sid_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input x86sid_pkg::out_t out_beat_o
);

  // a stalled result beat stays offered
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_beat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("result payload changed while stalled");

  // the pipeline only pushes back when the output side does
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with a free output");

  // every decoded instruction covers at least one byte
  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.length != 4'd0)
    else $error("zero instruction length");

  // a branch target form only comes with a jump or call class
  a_branch_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.operand_form == x86sid_pkg::FORM_BRANCH |->
      out_beat_o.op_class >= x86sid_pkg::OP_JE && out_beat_o.op_class <= x86sid_pkg::OP_CALL)
    else $error("branch form on a non-branch class");

endmodule

bind x86_64_subset_instruction_decoder_top x86sid_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
